/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Expects i_clk and i_rst_n to be visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, skipped while reset is asserted.
`define EFA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check on every clock edge, reset included.
`define EFA_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/efa_pkg.sv */
// Types, constants and the CRC-32 byte update for the FCS append core.
// No dependencies.
`default_nettype none

package efa_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CRC_W     = 32;
    localparam int unsigned FCS_IDX_W = 2;

    localparam logic [CRC_W-1:0]     CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0]     CRC_POLY     = 32'hEDB8_8320;
    localparam logic [FCS_IDX_W-1:0] FCS_IDX_LAST = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              frame_end;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_fcs;
        logic              out_end;
    } t_out_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [CRC_W-1:0]  fcs;
    } t_q_entry;

    function automatic logic [CRC_W-1:0] crc_fold_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] b
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/ethernet_fcs_append_core.sv */
// Path: an accepted byte is written into the queue, then into the output register.
// Throughput: one output byte per cycle while i_stall is low; a frame's end
// adds four FCS bytes; the queue absorbs input until it fills and stalls.
// Reset: CRC returns to all ones, queue empties, output valid drops.
// Depends on efa_pkg, efa_front, efa_fifo, efa_back.
`default_nettype none

module ethernet_fcs_append_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  efa_pkg::t_in_item    i_item,
    output logic                 o_valid,
    input  wire                  i_stall,
    output efa_pkg::t_out_item   o_item
);
    import efa_pkg::*;

    logic     push;
    logic     pop;
    logic     q_empty;
    logic     q_full;
    t_q_entry wr_entry;
    t_q_entry rd_entry;

    efa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .i_full  (q_full),
        .o_push  (push),
        .o_entry (wr_entry)
    );

    efa_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (wr_entry),
        .i_pop   (pop),
        .o_entry (rd_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    efa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (rd_entry),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

/* hw/rtl/efa_front.sv */
// Front end: accepts frame bytes, updates the running CRC-32, queues entries.
// Depends on efa_pkg.
`default_nettype none

module efa_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  efa_pkg::t_in_item    i_item,
    input  wire                  i_full,
    output logic                 o_push,
    output efa_pkg::t_q_entry    o_entry
);
    import efa_pkg::*;

    logic [CRC_W-1:0] r_crc;
    logic [CRC_W-1:0] n_crc;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;
    assign n_crc   = crc_fold_byte(r_crc, i_item.frame_byte);

    always_comb begin
        o_entry.data = i_item.frame_byte;
        o_entry.last = i_item.frame_end;
        o_entry.fcs  = ~n_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else if (o_push) begin
            r_crc <= i_item.frame_end ? CRC_INIT : n_crc;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/efa_fifo.sv */
// Short register queue between front and back ends.
// Depends on efa_pkg.
`default_nettype none

module efa_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  efa_pkg::t_q_entry    i_entry,
    input  wire                  i_pop,
    output efa_pkg::t_q_entry    o_entry,
    output logic                 o_empty,
    output logic                 o_full
);
    import efa_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_q_entry        r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            wr_en;
    logic            rd_en;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_FULL);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + AW'(1);
            end
            if (rd_en) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/efa_back.sv */
// Back end: drains queued bytes to the output register, appends four FCS bytes.
// Depends on efa_pkg.
`default_nettype none

module efa_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  efa_pkg::t_q_entry    i_entry,
    input  wire                  i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire                  i_stall,
    output efa_pkg::t_out_item   o_item
);
    import efa_pkg::*;

    logic                 r_valid;
    t_out_item            r_item;
    logic                 r_pend;
    logic [CRC_W-1:0]     r_fcs;
    logic [FCS_IDX_W-1:0] r_idx;
    logic                 load;

    assign load    = !r_valid || !i_stall;
    assign o_pop   = load && !r_pend && !i_empty;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_item.out_byte <= r_fcs[BYTE_W-1:0];
                r_item.is_fcs   <= 1'b1;
                r_item.out_end  <= (r_idx == FCS_IDX_LAST);
                r_fcs           <= r_fcs >> BYTE_W;
            end else begin
                r_item.out_byte <= i_entry.data;
                r_item.is_fcs   <= 1'b0;
                r_item.out_end  <= 1'b0;
                r_fcs           <= i_entry.fcs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_idx   <= r_idx + FCS_IDX_W'(1);
                if (r_idx == FCS_IDX_LAST) begin
                    r_pend <= 1'b0;
                end
            end else if (!i_empty) begin
                r_valid <= 1'b1;
                r_pend  <= i_entry.last;
                r_idx   <= '0;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/efa_checker.sv */
// Port-level checks for ethernet_fcs_append_core, bound to the top level.
// Depends on efa_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module efa_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wire                  o_stall,
    input  efa_pkg::t_in_item    i_item,
    input  wire                  o_valid,
    input  wire                  i_stall,
    input  efa_pkg::t_out_item   o_item
);
    import efa_pkg::*;

    `EFA_ASSERT(a_in_hold, i_valid && o_stall |=> i_valid && $stable(i_item), "input changed while stalled")
    `EFA_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_item), "output changed while stalled")
    `EFA_ASSERT(a_end_is_fcs, o_valid && o_item.out_end |-> o_item.is_fcs, "end mark on a non-FCS byte")
    `EFA_ASSERT(a_fcs_run, o_valid && !i_stall && o_item.is_fcs && !o_item.out_end |=> o_valid && o_item.is_fcs, "FCS bytes not back to back")
    `EFA_ASSERT_RST(a_rst_quiet, !i_rst_n |=> !o_valid, "output valid right after reset")

endmodule

bind ethernet_fcs_append_core efa_checker u_efa_checker (.*);

`default_nettype wire
